### rtl/swsfd_pkg.sv
`default_nettype none
package swsfd_pkg;

  localparam int HeaderSymbols = 2;
  localparam int FrameBits     = 40;
  localparam int WidthBits     = 15;
  localparam int FullCount     = HeaderSymbols + FrameBits;
  localparam int IdxBits       = 6;
  localparam int QueueDepth    = 2;

  localparam logic [WidthBits-1:0] LowMinReset  = WidthBits'(20);
  localparam logic [WidthBits-1:0] LowMaxReset  = WidthBits'(100);
  localparam logic [WidthBits-1:0] OneThrReset  = WidthBits'(40);

  typedef logic [WidthBits-1:0] width_t;

  typedef enum logic [1:0] {
    CFG_LOW_WIDTH_MIN = 2'd0,
    CFG_LOW_WIDTH_MAX = 2'd1,
    CFG_ONE_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_FEW  = 2'd1,
    ST_FRAMING  = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_t;

  // Classified symbol handed from the front end to the back end.
  typedef struct packed {
    logic is_data;   // symbol falls inside the 40 data bit slots
    logic fault;     // level or low width outside the window
    logic bit_val;   // high width at or above the one threshold
    logic last;      // end of capture
    logic complete;  // full frame seen once this symbol is counted
  } sym_t;

endpackage
`default_nettype wire

### rtl/swsfd_front.sv
`default_nettype none
module swsfd_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  [1:0]                  cfg_addr,
  input  wire  [swsfd_pkg::WidthBits-1:0] cfg_wdata,
  input  wire                         accept,
  input  wire                         first_level,
  input  wire  [swsfd_pkg::WidthBits-1:0] low_width,
  input  wire  [swsfd_pkg::WidthBits-1:0] high_width,
  input  wire                         capture_end,
  output swsfd_pkg::sym_t             sym
);

  swsfd_pkg::width_t low_min_r, low_max_r, one_thr_r;
  logic [swsfd_pkg::IdxBits-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_min_r <= swsfd_pkg::LowMinReset;
      low_max_r <= swsfd_pkg::LowMaxReset;
      one_thr_r <= swsfd_pkg::OneThrReset;
    end else if (cfg_we) begin
      unique case (swsfd_pkg::cfg_idx_t'(cfg_addr))
        swsfd_pkg::CFG_LOW_WIDTH_MIN: low_min_r <= cfg_wdata;
        swsfd_pkg::CFG_LOW_WIDTH_MAX: low_max_r <= cfg_wdata;
        swsfd_pkg::CFG_ONE_THRESHOLD: one_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Symbol counter, saturating at a full frame; restart after end of capture.
  always_comb begin
    idx_nxt = idx_r;
    if (accept) begin
      if (capture_end) begin
        idx_nxt = '0;
      end else if (idx_r < swsfd_pkg::IdxBits'(swsfd_pkg::FullCount)) begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_comb begin
    sym.is_data  = (idx_r >= swsfd_pkg::IdxBits'(swsfd_pkg::HeaderSymbols)) &&
                   (idx_r <  swsfd_pkg::IdxBits'(swsfd_pkg::FullCount));
    sym.fault    = first_level || (low_width < low_min_r) || (low_width > low_max_r);
    sym.bit_val  = (high_width >= one_thr_r);
    sym.last     = capture_end;
    sym.complete = (idx_r >= swsfd_pkg::IdxBits'(swsfd_pkg::FullCount - 1));
  end

endmodule
`default_nettype wire

### rtl/swsfd_queue.sv
`default_nettype none
module swsfd_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire swsfd_pkg::sym_t push_sym,
  output logic             full,
  input  wire              pop,
  output logic             head_valid,
  output swsfd_pkg::sym_t  head_sym
);

  swsfd_pkg::sym_t mem_r [swsfd_pkg::QueueDepth];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full       = (cnt_r == 2'(swsfd_pkg::QueueDepth));
  assign head_valid = (cnt_r != 2'd0);
  assign head_sym   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/swsfd_back.sv
`default_nettype none
module swsfd_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              head_valid,
  input  wire swsfd_pkg::sym_t head_sym,
  output logic             pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [1:0]       status,
  output logic [15:0]      raw_value,
  output logic             checksum_repaired
);

  logic [swsfd_pkg::FrameBits-1:0] shift_r, shift_nxt;
  logic fault_r, fault_nxt;
  logic out_valid_r, out_free;
  logic [1:0]  status_r;
  logic [15:0] raw_r;
  logic        rep_r;
  logic [7:0]  calc, chk;
  swsfd_pkg::status_t st;
  logic        rep;

  assign out_free = !out_valid_r || out_ready;
  // Hold the end of capture in the queue until the result slot is free.
  assign pop      = head_valid && (!head_sym.last || out_free);

  assign fault_nxt = fault_r || (head_sym.is_data && head_sym.fault);
  assign shift_nxt = head_sym.is_data ? {shift_r[swsfd_pkg::FrameBits-2:0], head_sym.bit_val}
                                      : shift_r;

  assign calc = shift_nxt[39:32] + shift_nxt[31:24] + shift_nxt[23:16] + shift_nxt[15:8];
  assign chk  = shift_nxt[7:0];

  always_comb begin
    rep = 1'b0;
    if (!head_sym.complete) begin
      st = swsfd_pkg::ST_TOO_FEW;
    end else if (fault_nxt) begin
      st = swsfd_pkg::ST_FRAMING;
    end else if (chk == calc) begin
      st = swsfd_pkg::ST_OK;
    end else if ((chk ^ 8'h01) == calc) begin
      st  = swsfd_pkg::ST_OK;
      rep = 1'b1;
    end else begin
      st = swsfd_pkg::ST_CHECKSUM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (head_sym.last) begin
          shift_r <= '0;
          fault_r <= 1'b0;
        end else begin
          shift_r <= shift_nxt;
          fault_r <= fault_nxt;
        end
      end
      if (pop && head_sym.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_sym.last) begin
      status_r <= st;
      raw_r    <= (st == swsfd_pkg::ST_OK) ? shift_nxt[39:24] : 16'd0;
      rep_r    <= (st == swsfd_pkg::ST_OK) && rep;
    end
  end

  assign out_valid         = out_valid_r;
  assign status            = status_r;
  assign raw_value         = raw_r;
  assign checksum_repaired = rep_r;

endmodule
`default_nettype wire

### rtl/single_wire_sensor_frame_decoder.sv
// Single-wire sensor frame decoder (40-bit temperature/humidity style frame).
// Input stream: one captured pulse symbol per transfer. in_tdata carries the
// start level, low width and high width (microseconds); in_tlast marks the
// last symbol of a capture. The first two symbols are header and skipped,
// the next 40 are data bits (MSB first), later ones are ignored.
// Output stream: exactly one result per capture, on the tlast symbol: status,
// big-endian raw value of bytes 0 and 1, and a checksum-repaired flag.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the low width window and the
// one threshold; write them only while no capture is in flight.
// Throughput: one symbol per cycle while the queue has room. Path: the tlast
// symbol enters the two-entry symbol queue at its transfer edge, then the back
// end pops it and loads the result register once the result slot is free,
// which raises out_tvalid.
// Stall: while out_tready is low the result holds; data symbols keep flowing
// into the queue, and in_tready drops only once the queue fills behind an
// end-of-capture symbol that waits for the result slot.
// Reset (rst_n low, synchronous): registers return to 20/100/40, the
// symbol count, frame shift and framing fault clear, queue and output empty.
`default_nettype none
module single_wire_sensor_frame_decoder (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [0] first_level, [15:1] low_width, [30:16] high_width
  input  wire         in_tlast,   // capture_end
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [1:0] status, [17:2] raw_value, [18] checksum_repaired
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire  [14:0] cfg_wdata
);

  logic            accept;
  logic            q_full, q_valid, q_pop;
  swsfd_pkg::sym_t front_sym, head_sym;
  logic [1:0]      status;
  logic [15:0]     raw_value;
  logic            checksum_repaired;

  // Take a symbol whenever the queue has room.
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Front end: count symbols and classify each against the registers.
  swsfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .first_level (in_tdata[0]),
    .low_width   (in_tdata[15:1]),
    .high_width  (in_tdata[30:16]),
    .capture_end (in_tlast),
    .sym         (front_sym)
  );

  // Short queue decouples symbol intake from result delivery.
  swsfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_sym   (front_sym),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_sym   (head_sym)
  );

  // Back end: assemble the frame, check it and drive the result register.
  swsfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_valid),
    .head_sym          (head_sym),
    .pop               (q_pop),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .status            (status),
    .raw_value         (raw_value),
    .checksum_repaired (checksum_repaired)
  );

  assign out_tdata = {5'd0, checksum_repaired, raw_value, status};

endmodule
`default_nettype wire

### rtl/swsfd_checker.sv
`default_nettype none
module swsfd_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // Raw value and repair flag are zero unless status is ok.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[18:2] == 17'd0)
    else $error("payload set on a failed capture");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind single_wire_sensor_frame_decoder swsfd_checker u_swsfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import swsfd_pkg::*;

  localparam int MaxWidth    = (1 << WidthBits) - 1;
  localparam int PhaseItems  = 165;
  localparam int LongHold    = 320;
  localparam int CycleLimit  = 200000;
  localparam int ReportLimit = 10;

  // One captured pulse symbol as the capture unit hands it over.
  typedef struct packed {
    logic   level;
    width_t low_w;
    width_t high_w;
    logic   last;
  } symbol_t;

  // One decoded capture as it should leave the block.
  typedef struct packed {
    status_t     status;
    logic [15:0] raw;
    logic        repaired;
  } frame_result_t;

  // How the checksum byte of a generated frame relates to the byte sum.
  typedef enum int {
    CHK_GOOD,
    CHK_REPAIR,
    CHK_WRONG
  } chk_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // [0] first_level, [15:1] low_width, [30:16] high_width
  logic        in_tlast   = 1'b0;  // capture_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;  // [1:0] status, [17:2] raw_value, [18] checksum_repaired
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = '0;
  width_t      cfg_wdata  = '0;

  single_wire_sensor_frame_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Decoder state mirrored on the testbench side; register copies track cfg writes.
  width_t                win_min     = LowMinReset;
  width_t                win_max     = LowMaxReset;
  width_t                one_thr     = OneThrReset;
  int unsigned           sym_count   = 0;
  logic [FrameBits-1:0]  frame_bits  = '0;
  logic                  frame_fault = 1'b0;

  symbol_t       symbols_to_send[$];
  frame_result_t expected_results[$];
  int            queued_syms    = 0;
  int            err_count      = 0;
  int            cycle_count    = 0;
  bit            calm           = 1'b0;  // no idling on either side while set
  int            long_hold_reqs = 0;
  int            long_hold_done = 0;

  // --------------------------------------------------------------------------
  // Frame decoder prediction: advance the capture by one symbol and queue
  // the expected result when the symbol closes the capture.
  // --------------------------------------------------------------------------
  task automatic decode_symbol(input symbol_t s);
    frame_result_t r;
    logic [7:0]    sum8;
    logic [7:0]    chk;
    // Symbols past the full frame only matter for their end mark.
    if (sym_count < FullCount) begin
      // Header symbols are counted but neither checked nor shifted in.
      if (sym_count >= HeaderSymbols) begin
        if (s.level || s.low_w < win_min || s.low_w > win_max) frame_fault = 1'b1;
        frame_bits = {frame_bits[FrameBits-2:0], s.high_w >= one_thr};
      end
      sym_count++;
    end
    if (s.last) begin
      r = '0;
      r.status = ST_OK;
      // Too few symbols wins over everything, then framing, then checksum.
      if (sym_count < FullCount) begin
        r.status = ST_TOO_FEW;
      end else if (frame_fault) begin
        r.status = ST_FRAMING;
      end else begin
        sum8 = frame_bits[39:32] + frame_bits[31:24] + frame_bits[23:16] + frame_bits[15:8];
        chk  = frame_bits[7:0];
        if (chk == sum8) begin
          r.status = ST_OK;
        end else if ((chk ^ 8'h01) == sum8) begin
          r.status   = ST_OK;
          r.repaired = 1'b1;
        end else begin
          r.status = ST_CHECKSUM;
        end
        if (r.status == ST_OK) r.raw = frame_bits[39:24];
      end
      expected_results.push_back(r);
      sym_count   = 0;
      frame_bits  = '0;
      frame_fault = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Symbol generation
  // --------------------------------------------------------------------------
  function automatic symbol_t random_symbol();
    symbol_t s;
    s.level = 1'($urandom_range(0, 1));
    s.last  = 1'b0;
    case ($urandom_range(0, 7))
      0: begin
        s.low_w  = '0;
        s.high_w = '1;
      end
      1: begin
        s.low_w  = '1;
        s.high_w = '0;
      end
      default: begin
        s.low_w  = width_t'($urandom);
        s.high_w = width_t'($urandom);
      end
    endcase
    return s;
  endfunction

  // Well-formed data symbol for one bit; hit the window and threshold edges often.
  function automatic symbol_t data_symbol(input logic one, input bit bad);
    symbol_t s;
    int      pick;
    int      pick_hi;
    pick    = $urandom_range(0, 3);
    pick_hi = $urandom_range(0, 3);
    s.level = 1'b0;
    s.last  = 1'b0;
    if (win_min <= win_max) begin
      if (pick == 0) s.low_w = win_min;
      else if (pick == 1) s.low_w = win_max;
      else s.low_w = width_t'($urandom_range(win_min, win_max));
    end else begin
      // Empty window: nothing passes, so any width will do.
      s.low_w = width_t'($urandom);
    end
    if (one) begin
      s.high_w = (pick_hi == 0) ? one_thr : width_t'($urandom_range(one_thr, MaxWidth));
    end else if (one_thr == 0) begin
      s.high_w = '0;
    end else begin
      s.high_w = (pick_hi == 0) ? width_t'(one_thr - 1) :
                                  width_t'($urandom_range(0, one_thr - 1));
    end
    if (bad) begin
      pick = $urandom_range(0, 2);
      if (pick == 1 && win_min > 0) begin
        s.low_w = width_t'($urandom_range(0, win_min - 1));
      end else if (pick == 2 && win_max < MaxWidth) begin
        s.low_w = width_t'($urandom_range(win_max + 1, MaxWidth));
      end else begin
        s.level = 1'b1;
      end
    end
    return s;
  endfunction

  // Queue one capture of 'total' symbols. fault_pos picks a data slot to break
  // (negative for none); noisy makes every symbol random.
  task automatic push_capture(input logic [31:0] payload, input chk_mode_t mode,
                              input int total, input int fault_pos, input bit noisy,
                              input bit rough_header);
    logic [7:0]           sum8;
    logic [7:0]           chk;
    logic [FrameBits-1:0] frame;
    symbol_t              s;
    int                   i;
    sum8 = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
    case (mode)
      CHK_REPAIR: chk = sum8 ^ 8'h01;
      CHK_WRONG:  chk = sum8 ^ 8'($urandom_range(2, 255));
      default:    chk = sum8;
    endcase
    frame = {payload, chk};
    for (i = 0; i < total; i++) begin
      if (noisy || i >= FullCount) begin
        s = random_symbol();
      end else if (i < HeaderSymbols) begin
        s = random_symbol();
        // Rough header: wrong level and widths far outside any window.
        if (rough_header) begin
          s.level = 1'b1;
          s.low_w = (i == 0) ? '0 : '1;
        end
      end else begin
        s = data_symbol(frame[FullCount-1-i], (i - HeaderSymbols) == fault_pos);
      end
      s.last = (i == total - 1);
      symbols_to_send.push_back(s);
      queued_syms++;
    end
  endtask

  // Half well-formed captures with random content, the rest broken or noise.
  task automatic push_random_capture();
    int          kind;
    int          total;
    int          fault;
    int          r;
    chk_mode_t   mode;
    logic [31:0] payload;
    kind    = $urandom_range(0, 99);
    payload = $urandom;
    r       = $urandom_range(0, 9);
    fault   = -1;
    total   = FullCount;
    if (r < 2) mode = CHK_REPAIR;
    else if (r < 4) mode = CHK_WRONG;
    else mode = CHK_GOOD;
    if (kind < 50) begin
      if ($urandom_range(0, 4) == 0) total = FullCount + $urandom_range(1, 4);
      push_capture(payload, mode, total, fault, 1'b0, 1'b0);
    end else if (kind < 65) begin
      fault = $urandom_range(0, FrameBits - 1);
      push_capture(payload, mode, total, fault, 1'b0, 1'b0);
    end else if (kind < 82) begin
      total = $urandom_range(1, FullCount - 1);
      if ($urandom_range(0, 1) == 1) fault = $urandom_range(0, FrameBits - 1);
      push_capture(payload, mode, total, fault, 1'b0, 1'b0);
    end else begin
      total = $urandom_range(1, FullCount + 6);
      push_capture(payload, mode, total, fault, 1'b1, 1'b0);
    end
  endtask

  // Hold until every queued symbol went out and every result came back.
  task automatic wait_drained(input int settle);
    while (symbols_to_send.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input width_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOW_WIDTH_MIN: win_min = value;
      CFG_LOW_WIDTH_MAX: win_max = value;
      CFG_ONE_THRESHOLD: one_thr = value;
      default: ;
    endcase
  endtask

  task automatic set_regs(input width_t lo, input width_t hi, input width_t thr);
    write_reg(CFG_LOW_WIDTH_MIN, lo);
    write_reg(CFG_LOW_WIDTH_MAX, hi);
    write_reg(CFG_ONE_THRESHOLD, thr);
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= ReportLimit) $display("mismatch: %s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Symbol driver: predict on every transfer, then refill from the pending
  // queue in bursts with random gaps. Never drop tvalid without a transfer.
  // --------------------------------------------------------------------------
  symbol_t on_wire;
  int      burst_left = 0;
  int      gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) decode_symbol(on_wire);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || symbols_to_send.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          on_wire = symbols_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, on_wire.high_w, on_wire.low_w, on_wire.level};
          in_tlast  <= on_wire.last;
          // End of burst: pick the next burst length and the gap before it.
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            if (calm || $urandom_range(0, 2) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and receiver. Check each transfer against the oldest
  // expectation; stall on a rotating pattern, or hold off for a long stretch
  // on request so the block backs up and stalls its input.
  // --------------------------------------------------------------------------
  frame_result_t want;
  logic [7:0]    stall_pat = 8'hff;
  int            pat_pos   = 0;
  int            hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          note_error($sformatf("result with nothing expected, tdata=%h", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[1:0] != want.status)
            note_error($sformatf("status exp %0d got %0d", want.status, out_tdata[1:0]));
          if (out_tdata[17:2] != want.raw)
            note_error($sformatf("raw_value exp %h got %h", want.raw, out_tdata[17:2]));
          if (out_tdata[18] != want.repaired)
            note_error($sformatf("checksum_repaired exp %0b got %0b",
                                 want.repaired, out_tdata[18]));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (long_hold_done != long_hold_reqs) begin
        long_hold_done++;
        hold_left = LongHold;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= stall_pat[pat_pos];
        pat_pos = (pat_pos + 1) % 8;
        // Swap the pattern now and then; keep one ready slot so it never locks.
        if (pat_pos == 0 && $urandom_range(0, 3) == 0) stall_pat = 8'($urandom) | 8'h01;
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    symbol_t lone;
    int      phase_start;
    bit      paused;
    width_t  lo;
    width_t  hi;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed captures on reset settings.
    // Single-symbol capture with extreme widths: too few symbols.
    lone        = random_symbol();
    lone.level  = 1'b1;
    lone.low_w  = '1;
    lone.high_w = '0;
    lone.last   = 1'b1;
    symbols_to_send.push_back(lone);
    queued_syms++;
    // Rough header, extra symbols after the frame, checksum off in its LSB.
    push_capture(32'hffff_ffff, CHK_REPAIR, FullCount + 3, -1, 1'b0, 1'b1);
    // Framing fault together with a bad checksum: framing wins.
    push_capture(32'h1234_5678, CHK_WRONG, FullCount, 0, 1'b0, 1'b0);
    // One symbol short with a fault: still too few.
    push_capture(32'h0000_0000, CHK_GOOD, FullCount - 1, 5, 1'b0, 1'b0);
    // Plain checksum error, and a clean all-zero frame.
    push_capture(32'ha5c3_0f81, CHK_WRONG, FullCount, -1, 1'b0, 1'b0);
    push_capture(32'h0000_0000, CHK_GOOD, FullCount, -1, 1'b0, 1'b0);
    wait_drained(4);

    // Random phases, each on its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs('0, '1, '0);
        1: set_regs('1, '1, '1);
        2: set_regs(width_t'(100), width_t'(50), width_t'(1000));  // empty window
        4: set_regs(LowMinReset, LowMaxReset, OneThrReset);
        default: begin
          lo = width_t'($urandom_range(0, 3000));
          hi = width_t'($urandom_range(lo, lo + 4000));
          set_regs(lo, hi, width_t'($urandom_range(0, MaxWidth)));
        end
      endcase
      calm        = (ph == 3);
      phase_start = queued_syms;
      paused      = 1'b0;
      while (queued_syms - phase_start < PhaseItems) begin
        push_random_capture();
        // Pause the sender midway until every result is back.
        if (ph == 5 && !paused && queued_syms - phase_start >= PhaseItems / 2) begin
          wait_drained(0);
          paused = 1'b1;
        end
      end
      // Long receiver hold-off while a full queue of symbols is on offer.
      if (ph == 0 || ph == 4) long_hold_reqs++;
      wait_drained(4);
    end

    wait_drained(8);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
